### hw/rtl/skrt_pkg.sv
`timescale 1ns / 1ps

package skrt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_REMOVE    = 2'd1;
    localparam logic [1:0] OP_DUMP_ASC  = 2'd2;
    localparam logic [1:0] OP_DUMP_DESC = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic signed [31:0] key;
        logic [7:0]         age;
        logic [63:0]        name_low;
        logic [63:0]        name_mid;
        logic [31:0]        name_high;
    } rec_t;

    // What a cell shows its neighbors and the readout
    typedef struct packed {
        rec_t rec;
        logic occ;
        logic after;
        logic eq;
        logic tok;
        logic term;
    } link_t;

    // Broadcast controls from the sequencer
    typedef struct packed {
        logic ins;
        logic rm_load;
        logic rm_shift;
        logic dump_load;
        logic step;
        logic desc;
    } cmd_t;

endpackage

### hw/rtl/skrt_req_if.sv
`timescale 1ns / 1ps

interface skrt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [63:0]        name_bytes_0_7;
    logic [63:0]        name_bytes_8_15;
    logic [31:0]        name_bytes_16_19;

    modport source (
        output valid, opcode, key, age, name_bytes_0_7, name_bytes_8_15, name_bytes_16_19,
        input  ready
    );
    modport sink (
        input  valid, opcode, key, age, name_bytes_0_7, name_bytes_8_15, name_bytes_16_19,
        output ready
    );
endinterface

### hw/rtl/skrt_rsp_if.sv
`timescale 1ns / 1ps

interface skrt_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic [7:0]         out_age;
    logic [63:0]        out_name_0_7;
    logic [63:0]        out_name_8_15;
    logic [31:0]        out_name_16_19;
    logic               last;

    modport source (
        output valid, status, out_key, out_age, out_name_0_7, out_name_8_15,
               out_name_16_19, last,
        input  ready
    );
    modport sink (
        input  valid, status, out_key, out_age, out_name_0_7, out_name_8_15,
               out_name_16_19, last,
        output ready
    );
endinterface

### hw/rtl/skrt_cell.sv
`timescale 1ns / 1ps

module skrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [skrt_pkg::CNT_W-1:0] idx,
    input  logic [skrt_pkg::CNT_W-1:0] count,
    input  skrt_pkg::cmd_t             cmd,
    input  skrt_pkg::rec_t             new_rec,
    input  skrt_pkg::link_t            left,
    input  skrt_pkg::link_t            right,
    output skrt_pkg::link_t            link
);
    import skrt_pkg::*;

    rec_t rec_reg;
    logic tok_reg;
    logic tok_next;
    logic ge_reg;
    logic occ;
    logic greater;
    logic eq;
    logic after;

    assign occ     = idx < count;
    assign greater = $signed(rec_reg.key) > $signed(new_rec.key);
    assign eq      = occ && (rec_reg.key == new_rec.key);
    assign after   = !occ || greater;

    assign link.rec   = rec_reg;
    assign link.occ   = occ;
    assign link.after = after;
    assign link.eq    = eq;
    assign link.tok   = tok_reg;
    assign link.term  = cmd.desc ? (idx == '0) : !right.occ;

    // shift right on insert, left on remove
    always_ff @(posedge clk)
    begin
        if (cmd.ins && after)
        begin
            rec_reg <= left.after ? left.rec : new_rec;
        end
        else if (cmd.rm_shift && ge_reg)
        begin
            rec_reg <= right.rec;
        end
    end

    always_comb
    begin
        tok_next = tok_reg;
        if (cmd.rm_load)
        begin
            tok_next = eq && !left.eq;
        end
        else if (cmd.dump_load)
        begin
            tok_next = cmd.desc ? (occ && !right.occ) : (idx == '0);
        end
        else if (cmd.step)
        begin
            tok_next = cmd.desc ? right.tok : left.tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            ge_reg  <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (cmd.rm_load)
            begin
                ge_reg <= !($signed(rec_reg.key) < $signed(new_rec.key));
            end
        end
    end

endmodule

### hw/rtl/sorted_keyed_record_table.sv
`timescale 1ns / 1ps

// Sorted record table, up to CAPACITY records kept in ascending signed key order.
// req carries one command beat: opcode, key, age and the 20 name bytes.
// rsp carries result beats: status, the record fields and a last mark.
// Insert: one beat (ok or full), registered, in the cycle after acceptance; a new
//   command can be taken every cycle while rsp keeps up.
// Remove: one beat; acceptance loads the match token, the REMOVE state then
//   registers the beat once rsp is free, and only then is a new command taken.
// Dump: n beats, one per cycle while rsp keeps up; acceptance loads the read
//   token, then each beat is registered from it, last mark on the final one;
//   an empty table gives one empty-status beat in the cycle after acceptance.
// The cell row does the work: every cell compares its key against the
// command at once, and a one-hot read token walks the row, one cell per
// beat, into the output register.
// Reset empties the table; record contents need no clearing.
// A stalled rsp holds its beat and freezes the sequencer; req.ready drops
// until the output register frees.

module sorted_keyed_record_table (
    input  logic       clk,
    input  logic       rst_n,
    skrt_req_if.sink   req,
    skrt_rsp_if.source rsp
);
    import skrt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_DUMP   = 2'd2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam int REC_W = $bits(rec_t);

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             desc_reg;
    logic             desc_next;
    logic             ov_reg;
    logic             ov_next;
    rec_t             out_rec_reg;
    rec_t             out_rec_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             last_reg;
    logic             last_next;

    cmd_t             cmd;
    rec_t             new_rec;
    link_t            links [CAPACITY];
    link_t            lefts [CAPACITY];
    link_t            rights[CAPACITY];
    logic [CAPACITY-1:0] tok_vec;

    logic [REC_W-1:0] sel_bits;
    rec_t             sel_rec;
    logic             found;
    logic             sel_last;
    logic             slot_free;
    logic             accept;

    assign new_rec.key       = req.key;
    assign new_rec.age       = req.age;
    assign new_rec.name_low  = req.name_bytes_0_7;
    assign new_rec.name_mid  = req.name_bytes_8_15;
    assign new_rec.name_high = req.name_bytes_16_19;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_l0
                assign lefts[g] = '0;
            end
            else
            begin : g_ln
                assign lefts[g] = links[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_rl
                assign rights[g] = '0;
            end
            else
            begin : g_rn
                assign rights[g] = links[g+1];
            end

            skrt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (CNT_W'(g)),
                .count   (count_reg),
                .cmd     (cmd),
                .new_rec (new_rec),
                .left    (lefts[g]),
                .right   (rights[g]),
                .link    (links[g])
            );

            assign tok_vec[g] = links[g].tok;
        end
    endgenerate

    // one-hot readout of the cell holding the token
    always_comb
    begin
        sel_bits = '0;
        found    = 1'b0;
        sel_last = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_bits = sel_bits | (links[i].rec & {REC_W{links[i].tok}});
            found    = found | links[i].tok;
            sel_last = sel_last | (links[i].tok & links[i].term);
        end
    end

    assign sel_rec   = rec_t'(sel_bits);
    assign slot_free = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        desc_next    = desc_reg;
        ov_next      = ov_reg && !rsp.ready;
        out_rec_next = out_rec_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.desc     = (state_reg == S_IDLE) ? (req.opcode == OP_DUMP_DESC) : desc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        OP_INSERT:
                        begin
                            ov_next      = 1'b1;
                            out_rec_next = '0;
                            last_next    = 1'b1;
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                cmd.ins     = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            cmd.rm_load = 1'b1;
                            state_next  = S_REMOVE;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                ov_next      = 1'b1;
                                out_rec_next = '0;
                                status_next  = ST_EMPTY;
                                last_next    = 1'b1;
                            end
                            else
                            begin
                                cmd.dump_load = 1'b1;
                                desc_next     = (req.opcode == OP_DUMP_DESC);
                                state_next    = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                    if (found)
                    begin
                        out_rec_next = sel_rec;
                        status_next  = ST_OK;
                        cmd.rm_shift = 1'b1;
                        count_next   = count_reg - 1'b1;
                    end
                    else
                    begin
                        out_rec_next = '0;
                        status_next  = ST_NOT_FOUND;
                    end
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    ov_next      = 1'b1;
                    out_rec_next = sel_rec;
                    status_next  = ST_OK;
                    last_next    = sel_last;
                    cmd.step     = 1'b1;
                    if (sel_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            desc_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            desc_reg  <= desc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg <= out_rec_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign rsp.valid          = ov_reg;
    assign rsp.status         = status_reg;
    assign rsp.out_key        = out_rec_reg.key;
    assign rsp.out_age        = out_rec_reg.age;
    assign rsp.out_name_0_7   = out_rec_reg.name_low;
    assign rsp.out_name_8_15  = out_rec_reg.name_mid;
    assign rsp.out_name_16_19 = out_rec_reg.name_high;
    assign rsp.last           = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_dump_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> $onehot(tok_vec))
        else $error("dump token lost or duplicated");

    a_remove_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |-> $onehot0(tok_vec))
        else $error("more than one remove match");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == OP_INSERT && count_reg != CAP_CNT)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table");

endmodule

### verif/tb_sorted_keyed_record_table.sv
`timescale 1ns / 1ps

module tb_sorted_keyed_record_table;
    import skrt_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_CMDS = 186;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [1:0] opcode;
        rec_t       rec;
    } table_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        rec_t       rec;
        logic       last;
    } table_beat_t;

    logic clk;
    logic rst_n;

    skrt_req_if req_bus ();
    skrt_rsp_if rsp_bus ();

    sorted_keyed_record_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    rec_t        table_recs [CAPACITY];
    int          table_count = 0;
    table_beat_t pending_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          rsp_hold_request = 0;
    int          burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic table_cmd_t make_cmd(input logic [1:0] op, input logic [31:0] key,
                                            input logic [7:0] age, input logic [63:0] n0,
                                            input logic [63:0] n1, input logic [31:0] n2);
        table_cmd_t c;
        c.opcode        = op;
        c.rec.key       = key;
        c.rec.age       = age;
        c.rec.name_low  = n0;
        c.rec.name_mid  = n1;
        c.rec.name_high = n2;
        return c;
    endfunction

    function automatic table_beat_t blank_beat(input logic [1:0] status);
        table_beat_t b;
        b.status = status;
        b.rec    = '0;
        b.last   = 1'b1;
        return b;
    endfunction

    // Mirror of the table: update contents and queue the beats this command produces
    task automatic apply_to_table(input table_cmd_t c);
        int          pos;
        int          i;
        int          idx;
        table_beat_t b;
        case (c.opcode)
            OP_INSERT:
            begin
                if (table_count >= CAPACITY)
                begin
                    pending_results.push_back(blank_beat(ST_FULL));
                end
                else
                begin
                    pos = table_count;
                    for (i = 0; i < table_count; i++)
                    begin
                        if ($signed(table_recs[i].key) > $signed(c.rec.key))
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = table_count; i > pos; i--)
                        table_recs[i] = table_recs[i - 1];
                    table_recs[pos] = c.rec;
                    table_count++;
                    pending_results.push_back(blank_beat(ST_OK));
                end
            end
            OP_REMOVE:
            begin
                pos = -1;
                for (i = 0; i < table_count; i++)
                begin
                    if (table_recs[i].key == c.rec.key)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos < 0)
                begin
                    pending_results.push_back(blank_beat(ST_NOT_FOUND));
                end
                else
                begin
                    b.status = ST_OK;
                    b.rec    = table_recs[pos];
                    b.last   = 1'b1;
                    pending_results.push_back(b);
                    for (i = pos; i + 1 < table_count; i++)
                        table_recs[i] = table_recs[i + 1];
                    table_count--;
                end
            end
            default:
            begin
                if (table_count == 0)
                begin
                    pending_results.push_back(blank_beat(ST_EMPTY));
                end
                else
                begin
                    for (i = 0; i < table_count; i++)
                    begin
                        idx      = (c.opcode == OP_DUMP_ASC) ? i : table_count - 1 - i;
                        b.status = ST_OK;
                        b.rec    = table_recs[idx];
                        b.last   = (i + 1 == table_count);
                        pending_results.push_back(b);
                    end
                end
            end
        endcase
    endtask

    // Sender works in bursts; between bursts valid drops for a random gap
    task automatic send_cmd(input table_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        req_bus.valid            <= 1'b1;
        req_bus.opcode           <= c.opcode;
        req_bus.key              <= c.rec.key;
        req_bus.age              <= c.rec.age;
        req_bus.name_bytes_0_7   <= c.rec.name_low;
        req_bus.name_bytes_8_15  <= c.rec.name_mid;
        req_bus.name_bytes_16_19 <= c.rec.name_high;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        apply_to_table(c);
    endtask

    task automatic test_empty_table();
        send_cmd(make_cmd(OP_DUMP_ASC, 32'd0, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_DUMP_DESC, 32'd0, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_REMOVE, 32'd0, 8'd0, '0, '0, '0));
    endtask

    task automatic test_fill_to_full();
        logic [31:0] keys [16];
        logic [63:0] n0;
        logic [63:0] n1;
        logic [31:0] n2;
        logic [7:0]  age;
        int          i;
        keys = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd5, 32'd5,
                 32'd5, 32'hFFFF_FFF9, 32'd100, 32'h5555_5555, 32'hAAAA_AAAA, 32'd3,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'd42};
        for (i = 0; i < 16; i++)
        begin
            age = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom);
            case (i % 3)
                0:       {n0, n1, n2} = '0;
                1:       {n0, n1, n2} = '1;
                default: {n0, n1, n2} = {$urandom, $urandom, $urandom, $urandom, $urandom};
            endcase
            send_cmd(make_cmd(OP_INSERT, keys[i], age, n0, n1, n2));
        end
        send_cmd(make_cmd(OP_INSERT, 32'd9, 8'd77, '1, '0, '1));
        send_cmd(make_cmd(OP_DUMP_ASC, 32'd0, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_DUMP_DESC, 32'd0, 8'd0, '0, '0, '0));
    endtask

    task automatic test_remove_cases();
        send_cmd(make_cmd(OP_REMOVE, 32'd5, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_REMOVE, 32'd12345, 8'd0, '0, '0, '0));
    endtask

    // Receiver holds off while commands keep coming, so the block stalls req
    task automatic test_rsp_backpressure();
        rsp_hold_request = HOLD_CYCLES;
        burst_left       = 1000;
        send_cmd(make_cmd(OP_DUMP_DESC, 32'd0, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_INSERT, 32'd7, 8'd200, {2{$urandom}}, {2{$urandom}}, $urandom));
        send_cmd(make_cmd(OP_INSERT, 32'd8, 8'd201, '0, '0, '0));
        send_cmd(make_cmd(OP_DUMP_ASC, 32'd0, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_REMOVE, 32'h7FFF_FFFF, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(OP_REMOVE, 32'd9999, 8'd0, '0, '0, '0));
        burst_left = 0;
    endtask

    // Alternating fill and drain phases so the table reaches both full and empty
    task automatic test_random_traffic();
        int          n;
        int          r;
        int          ins_w;
        int          rm_w;
        logic [1:0]  op;
        logic [31:0] key;
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            if (((n / 40) % 2) == 0)
            begin
                ins_w = 60;
                rm_w  = 20;
            end
            else
            begin
                ins_w = 15;
                rm_w  = 60;
            end
            r = $urandom_range(0, 99);
            if (r < ins_w)
                op = OP_INSERT;
            else if (r < ins_w + rm_w)
                op = OP_REMOVE;
            else
                op = $urandom_range(0, 1) ? OP_DUMP_ASC : OP_DUMP_DESC;

            if (op == OP_REMOVE && table_count > 0 && $urandom_range(0, 4) != 0)
                key = table_recs[$urandom_range(0, table_count - 1)].key;
            else if ($urandom_range(0, 1))
                key = 32'($signed($urandom_range(0, 8)) - 4);
            else
                key = $urandom;

            send_cmd(make_cmd(op, key, 8'($urandom), {$urandom, $urandom},
                              {$urandom, $urandom}, $urandom));
        end
    endtask

    initial
    begin : rsp_side
        int          mode;
        int          seg_left;
        int          hold_left;
        int          phase;
        table_beat_t got;
        table_beat_t want;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        phase     = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.status        = rsp_bus.status;
                got.rec.key       = rsp_bus.out_key;
                got.rec.age       = rsp_bus.out_age;
                got.rec.name_low  = rsp_bus.out_name_0_7;
                got.rec.name_mid  = rsp_bus.out_name_8_15;
                got.rec.name_high = rsp_bus.out_name_16_19;
                got.last          = rsp_bus.last;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected beat: status=%0d key=%0d last=%0b",
                                 got.status, $signed(got.rec.key), got.last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.rec.key !== want.rec.key ||
                        got.rec.age !== want.rec.age ||
                        got.rec.name_low !== want.rec.name_low ||
                        got.rec.name_mid !== want.rec.name_mid ||
                        got.rec.name_high !== want.rec.name_high || got.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch exp: st=%0d key=%0d age=%0d name=%h_%h_%h last=%0b",
                                     want.status, $signed(want.rec.key), want.rec.age,
                                     want.rec.name_high, want.rec.name_mid,
                                     want.rec.name_low, want.last);
                            $display("         got: st=%0d key=%0d age=%0d name=%h_%h_%h last=%0b",
                                     got.status, $signed(got.rec.key), got.rec.age,
                                     got.rec.name_high, got.rec.name_mid,
                                     got.rec.name_low, got.last);
                        end
                    end
                end
            end

            if (rsp_hold_request > 0)
            begin
                hold_left        = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_bus.ready <= 1'b1;
                    1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_bus.ready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : main
        rst_n                    = 1'b0;
        req_bus.valid            = 1'b0;
        req_bus.opcode           = OP_INSERT;
        req_bus.key              = '0;
        req_bus.age              = '0;
        req_bus.name_bytes_0_7   = '0;
        req_bus.name_bytes_8_15  = '0;
        req_bus.name_bytes_16_19 = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_fill_to_full();
        test_remove_cases();
        test_rsp_backpressure();
        test_random_traffic();

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        error_count += pending_results.size();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
